[rtl/dpc_pkg.sv]
// shared constants, register indexes and control types for the depth pixel to point block
// no dependencies
package dpc_pkg;

    localparam int DEPTH_W     = 24;
    localparam int COLOR_W     = 8;
    localparam int COORD_W     = 24;
    localparam int PACKED_W    = 3 * COLOR_W;
    localparam int CFG_SIDE_W  = 13;
    localparam int INV_W       = 32;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int PROD_W      = DEPTH_W + INV_W;
    localparam int SPLIT_W     = PROD_W / 2;
    localparam int FRAC_SHIFT  = 33;
    localparam int MAX_SIDE_DEF = 4096;

    localparam logic [CFG_SIDE_W-1:0] RST_WIDTH  = 13'd640;
    localparam logic [CFG_SIDE_W-1:0] RST_HEIGHT = 13'd480;
    localparam logic [INV_W-1:0]      RST_INV_X  = 32'd5559491;
    localparam logic [INV_W-1:0]      RST_INV_Y  = 32'd7412641;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y  = 8'd3;

    typedef struct packed {
        logic accept;
        logic prod_en;
        logic part_en;
        logic sum_en;
        logic out_load;
    } t_dp_cmd;

endpackage

[rtl/depth_pixel_to_point_cloud_core.sv]
// depth pixel to point cloud back-projection, top level
// a pixel is taken only in idle, then runs the four-step multiply, partial product,
// sum and saturate sequence; saturate waits while the output register is still full;
// a finished point waits in the output register while the next pixel is taken
// reset (synchronous, active low) restores default geometry and clears counters and valid
// depends on dpc_pkg, dpc_ctrl, dpc_datapath
module depth_pixel_to_point_cloud_core #(
    parameter int MAX_SIDE = dpc_pkg::MAX_SIDE_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic        [dpc_pkg::DEPTH_W-1:0]    i_depth,
    input  logic        [dpc_pkg::COLOR_W-1:0]    i_red,
    input  logic        [dpc_pkg::COLOR_W-1:0]    i_green,
    input  logic        [dpc_pkg::COLOR_W-1:0]    i_blue,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic        [dpc_pkg::DEPTH_W-1:0]    o_forward,
    output logic signed [dpc_pkg::COORD_W-1:0]    o_lateral,
    output logic signed [dpc_pkg::COORD_W-1:0]    o_vertical,
    output logic        [dpc_pkg::PACKED_W-1:0]   o_packed_colour,
    output logic                                  o_frame_end,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [dpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [dpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    dpc_pkg::t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    dpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    dpc_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_write     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_depth         (i_depth),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .o_forward       (o_forward),
        .o_lateral       (o_lateral),
        .o_vertical      (o_vertical),
        .o_packed_colour (o_packed_colour),
        .o_frame_end     (o_frame_end)
    );

endmodule

[rtl/dpc_ctrl.sv]
// sequencing state machine and output valid flag
// depends on dpc_pkg
module dpc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output dpc_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PROD = 5'b00010,
        S_PART = 5'b00100,
        S_SUM  = 5'b01000,
        S_SAT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   load;

    assign load = (r_state == S_SAT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PROD;
                end
            end
            S_PROD:  n_state = S_PART;
            S_PART:  n_state = S_SUM;
            S_SUM:   n_state = S_SAT;
            S_SAT: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.prod_en  = (r_state == S_PROD);
    assign o_cmd.part_en  = (r_state == S_PART);
    assign o_cmd.sum_en   = (r_state == S_SUM);
    assign o_cmd.out_load = load;

endmodule

[rtl/dpc_datapath.sv]
// config registers, pixel counters, projection arithmetic and output register
// depends on dpc_pkg
module dpc_datapath #(
    parameter int MAX_SIDE = dpc_pkg::MAX_SIDE_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  dpc_pkg::t_dp_cmd                      i_cmd,
    input  logic                                  i_cfg_write,
    input  logic        [dpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [dpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic        [dpc_pkg::DEPTH_W-1:0]    i_depth,
    input  logic        [dpc_pkg::COLOR_W-1:0]    i_red,
    input  logic        [dpc_pkg::COLOR_W-1:0]    i_green,
    input  logic        [dpc_pkg::COLOR_W-1:0]    i_blue,
    output logic        [dpc_pkg::DEPTH_W-1:0]    o_forward,
    output logic signed [dpc_pkg::COORD_W-1:0]    o_lateral,
    output logic signed [dpc_pkg::COORD_W-1:0]    o_vertical,
    output logic        [dpc_pkg::PACKED_W-1:0]   o_packed_colour,
    output logic                                  o_frame_end
);

    localparam int CNT_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int EW     = SIDE_W + 1;
    localparam int AW     = SIDE_W + 1;
    localparam int DW     = SIDE_W + 2;
    localparam int PART_W = AW + dpc_pkg::SPLIT_W;
    localparam int FULL_W = AW + dpc_pkg::PROD_W;
    localparam int Q_W    = FULL_W - dpc_pkg::FRAC_SHIFT;
    localparam logic [Q_W:0] SAT_MAG = (Q_W + 1)'(1) << (dpc_pkg::COORD_W - 1);
    localparam logic [Q_W:0] POS_MAX = SAT_MAG - (Q_W + 1)'(1);

    function automatic logic [SIDE_W-1:0] eff_side(input logic [dpc_pkg::CFG_SIDE_W-1:0] v);
        logic [SIDE_W-1:0] s;
        if (v == '0) begin
            s = SIDE_W'(1);
        end else if (32'(v) > 32'(MAX_SIDE)) begin
            s = SIDE_W'(MAX_SIDE);
        end else begin
            s = SIDE_W'(v);
        end
        return s;
    endfunction

    function automatic logic [AW:0] offset(input logic [CNT_W-1:0] pos,
                                           input logic [SIDE_W-1:0] side);
        logic signed [DW-1:0] d2;
        logic        [AW-1:0] a;
        d2 = signed'(DW'({pos, 1'b0})) - signed'(DW'(side));
        a  = (d2 < 0) ? AW'(-d2) : AW'(d2);
        return {d2 > 0, a};
    endfunction

    function automatic logic [dpc_pkg::COORD_W-1:0] saturate(input logic [FULL_W-1:0] full,
                                                             input logic neg);
        logic [Q_W-1:0] q;
        logic           rem;
        logic [Q_W:0]   mag;
        logic [dpc_pkg::COORD_W-1:0] res;
        q   = full[FULL_W-1:dpc_pkg::FRAC_SHIFT];
        rem = |full[dpc_pkg::FRAC_SHIFT-1:0];
        mag = (Q_W + 1)'(q) + (Q_W + 1)'(rem);
        if (neg) begin
            if (mag > SAT_MAG) begin
                res = dpc_pkg::COORD_W'(SAT_MAG);
            end else begin
                res = dpc_pkg::COORD_W'((Q_W + 1)'(0) - mag);
            end
        end else if ((Q_W + 1)'(q) > POS_MAX) begin
            res = dpc_pkg::COORD_W'(POS_MAX);
        end else begin
            res = dpc_pkg::COORD_W'(q);
        end
        return res;
    endfunction

    // config registers
    logic [dpc_pkg::CFG_SIDE_W-1:0] r_width, r_height;
    logic [dpc_pkg::INV_W-1:0]      r_inv_x, r_inv_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= dpc_pkg::RST_WIDTH;
            r_height <= dpc_pkg::RST_HEIGHT;
            r_inv_x  <= dpc_pkg::RST_INV_X;
            r_inv_y  <= dpc_pkg::RST_INV_Y;
        end else if (i_cfg_write) begin
            case (i_cfg_index)
                dpc_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[dpc_pkg::CFG_SIDE_W-1:0];
                dpc_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[dpc_pkg::CFG_SIDE_W-1:0];
                dpc_pkg::CFG_INV_FOCAL_X:  r_inv_x  <= i_cfg_data[dpc_pkg::INV_W-1:0];
                dpc_pkg::CFG_INV_FOCAL_Y:  r_inv_y  <= i_cfg_data[dpc_pkg::INV_W-1:0];
                default: ;
            endcase
        end
    end

    // pixel position counters
    logic [CNT_W-1:0]  r_col, r_row, n_col, n_row;
    logic [SIDE_W-1:0] side_w, side_h;
    logic              row_end, frame_end;
    logic [AW:0]       off_x, off_y;

    assign side_w    = eff_side(r_width);
    assign side_h    = eff_side(r_height);
    assign row_end   = (EW'(r_col) + EW'(1)) >= EW'(side_w);
    assign frame_end = row_end && ((EW'(r_row) + EW'(1)) >= EW'(side_h));
    assign off_x     = offset(r_col, side_w);
    assign off_y     = offset(r_row, side_h);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (row_end) begin
            n_col = '0;
            n_row = frame_end ? '0 : r_row + CNT_W'(1);
        end else begin
            n_col = r_col + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // per pixel pipeline registers
    logic [dpc_pkg::DEPTH_W-1:0]  r_depth;
    logic [dpc_pkg::PACKED_W-1:0] r_colour;
    logic                         r_fe;
    logic [AW-1:0]                r_ax, r_ay;
    logic                         r_neg_x, r_neg_y;
    logic [dpc_pkg::PROD_W-1:0]   r_px, r_py;
    logic [PART_W-1:0]            r_lo_x, r_hi_x, r_lo_y, r_hi_y;
    logic [FULL_W-1:0]            r_full_x, r_full_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_depth  <= i_depth;
            r_colour <= {i_red, i_green, i_blue};
            r_fe     <= frame_end;
            r_neg_x  <= off_x[AW];
            r_ax     <= off_x[AW-1:0];
            r_neg_y  <= off_y[AW];
            r_ay     <= off_y[AW-1:0];
        end
        if (i_cmd.prod_en) begin
            r_px <= dpc_pkg::PROD_W'(r_depth) * dpc_pkg::PROD_W'(r_inv_x);
            r_py <= dpc_pkg::PROD_W'(r_depth) * dpc_pkg::PROD_W'(r_inv_y);
        end
        if (i_cmd.part_en) begin
            r_lo_x <= PART_W'(r_ax) * PART_W'(r_px[dpc_pkg::SPLIT_W-1:0]);
            r_hi_x <= PART_W'(r_ax) * PART_W'(r_px[dpc_pkg::PROD_W-1:dpc_pkg::SPLIT_W]);
            r_lo_y <= PART_W'(r_ay) * PART_W'(r_py[dpc_pkg::SPLIT_W-1:0]);
            r_hi_y <= PART_W'(r_ay) * PART_W'(r_py[dpc_pkg::PROD_W-1:dpc_pkg::SPLIT_W]);
        end
        if (i_cmd.sum_en) begin
            r_full_x <= (FULL_W'(r_hi_x) << dpc_pkg::SPLIT_W) + FULL_W'(r_lo_x);
            r_full_y <= (FULL_W'(r_hi_y) << dpc_pkg::SPLIT_W) + FULL_W'(r_lo_y);
        end
    end

    // output register
    logic [dpc_pkg::DEPTH_W-1:0]  r_out_fwd;
    logic [dpc_pkg::COORD_W-1:0]  r_out_lat, r_out_ver;
    logic [dpc_pkg::PACKED_W-1:0] r_out_col;
    logic                         r_out_fe;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_fwd <= r_depth;
            r_out_lat <= saturate(r_full_x, r_neg_x);
            r_out_ver <= saturate(r_full_y, r_neg_y);
            r_out_col <= r_colour;
            r_out_fe  <= r_fe;
        end
    end

    assign o_forward       = r_out_fwd;
    assign o_lateral       = signed'(r_out_lat);
    assign o_vertical      = signed'(r_out_ver);
    assign o_packed_colour = r_out_col;
    assign o_frame_end     = r_out_fe;

endmodule
